// File: design/grid_local_peak_finder_macros.svh
// assertion macros for the grid local peak finder checker
// no dependencies, included by the checker file only
`ifndef GRID_LOCAL_PEAK_FINDER_MACROS_SVH
`define GRID_LOCAL_PEAK_FINDER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define GLPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define GLPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/glpf_pkg.sv
// shared types, constants and helpers for the grid local peak finder
// no dependencies
`default_nettype none

package glpf_pkg;

   localparam int ConfigBits = 9;
   localparam int RowLimit   = 256;
   localparam int CoordBits  = 8;
   localparam int QueueDepth = 2;

   typedef enum logic {
      REG_ROW_COUNT    = 1'b0,
      REG_COLUMN_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CoordBits-1:0] row;
      logic [CoordBits-1:0] column;
   } peak_type;

   // zero reads as one, anything above the limit reads as the limit
   function automatic logic [ConfigBits-1:0] clamp_count(input logic [ConfigBits-1:0] raw,
                                                          input int unsigned limit);
      logic [31:0] wide;
      wide = 32'(raw);
      if (raw == '0) begin
         return ConfigBits'(1);
      end
      if (wide > limit) begin
         return ConfigBits'(limit);
      end
      return raw;
   endfunction

endpackage

`default_nettype wire

// File: design/glpf_cell.sv
// one cell of the row delay chain: a slot of the row above and of the row two above
// no package dependency
`default_nettype none

module glpf_cell #(
   parameter int VALUE_BITS = 16,
   parameter int INDEX      = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         shift,
   input  wire logic [8:0]                   column_count,
   input  wire logic signed [VALUE_BITS-1:0] entry_one,
   input  wire logic signed [VALUE_BITS-1:0] entry_two,
   input  wire logic                         nb_valid,
   input  wire logic signed [VALUE_BITS-1:0] nb_one,
   input  wire logic signed [VALUE_BITS-1:0] nb_two,
   output logic                              cell_valid,
   output logic signed [VALUE_BITS-1:0]      cell_one,
   output logic signed [VALUE_BITS-1:0]      cell_two
);

   logic                         valid_ff, valid_in;
   logic signed [VALUE_BITS-1:0] one_ff, one_in;
   logic signed [VALUE_BITS-1:0] two_ff, two_in;
   logic                         is_entry;

   // new words join the chain at the cell that ends the active row length
   assign is_entry = (32'(column_count) == 32'(INDEX + 1));

   always_comb begin
      valid_in = is_entry ? 1'b1      : nb_valid;
      one_in   = is_entry ? entry_one : nb_one;
      two_in   = is_entry ? entry_two : nb_two;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         one_ff <= one_in;
         two_ff <= two_in;
      end
   end

   // an empty slot reads as the zero border
   assign cell_valid = valid_ff;
   assign cell_one   = valid_ff ? one_ff : '0;
   assign cell_two   = valid_ff ? two_ff : '0;

endmodule

`default_nettype wire

// File: design/glpf_out_queue.sv
// two-entry result queue between the detector and the result channel
// depends on glpf_pkg for the peak type and depth
`default_nettype none

module glpf_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire glpf_pkg::peak_type push_item,
   output logic                    full,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output glpf_pkg::peak_type      rsp_item
);
   import glpf_pkg::*;

   localparam int PtrBits   = $clog2(QueueDepth);
   localparam int CountBits = $clog2(QueueDepth + 1);

   peak_type             slot_ff [QueueDepth];
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 pop;

   assign pop = (count_ff != '0) && !rsp_stall;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CountBits'(QueueDepth));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: design/grid_local_peak_finder.sv
// grid local peak finder: four-neighbour local maxima of a raster-order grid stream
// depends on glpf_pkg, glpf_cell and glpf_out_queue
//
// usage
//   req channel: one grid word per accepted cycle, req_kind 0 for a real cell,
//   1 for a flush cell; after the last real row software sends one flush word
//   per column to stand for the zero bottom border
//   rsp channel: one word per peak, row and column 0-based, in raster order;
//   rsp_last_of_run is always high since a word causes at most one peak
//   csr port: row_count at byte 0, column_count at byte 4, values clamped to
//   1..256 and 1..MAX_COLUMNS; a write restarts the grid
// timing
//   a centre is decided when the word below it is accepted, and its peak word
//   is queued and offered on rsp; throughput is one word per cycle while
//   req_stall is low: the cell chain shifts once per accepted word and the compare
//   uses the chain head, the next cell, the left neighbour and the arriving word
// reset and stall
//   reset sets both counts to 1, empties the row chain (all zero border) and
//   the result queue
//   a stalled receiver fills the two-entry result queue; req_stall rises only
//   while both entries are held
`default_nettype none

module grid_local_peak_finder #(
   parameter int MAX_COLUMNS = 256,
   parameter int VALUE_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input words
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_kind,
   input  wire logic signed [VALUE_BITS-1:0] req_cell_value,
   // result words
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [glpf_pkg::CoordBits-1:0]    rsp_peak_row,
   output logic [glpf_pkg::CoordBits-1:0]    rsp_peak_column,
   output logic                              rsp_last_of_run,
   // configuration
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [2:0]                   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import glpf_pkg::*;

   // column position never exceeds what the 9-bit count can express
   localparam int ColBits = (MAX_COLUMNS > 512) ? ConfigBits : $clog2(MAX_COLUMNS);

   // configuration registers
   logic [ConfigBits-1:0] row_count_ff, row_count_in;
   logic [ConfigBits-1:0] column_count_ff, column_count_in;

   // stream position and left neighbour
   logic [ConfigBits-1:0]        row_pos_ff, row_pos_in;
   logic [ColBits-1:0]           col_pos_ff, col_pos_in;
   logic signed [VALUE_BITS-1:0] prev_ff, prev_in;

   // cell chain taps
   logic                         chain_valid [MAX_COLUMNS];
   logic signed [VALUE_BITS-1:0] chain_one   [MAX_COLUMNS];
   logic signed [VALUE_BITS-1:0] chain_two   [MAX_COLUMNS];

   logic                         cfg_write;
   reg_index_type                cfg_index;
   logic                         accept;
   logic                         bottom;
   logic                         last_col;
   logic [ConfigBits:0]          col_next;
   logic                         restart;
   logic signed [VALUE_BITS-1:0] down;
   logic signed [VALUE_BITS-1:0] centre;
   logic signed [VALUE_BITS-1:0] up;
   logic signed [VALUE_BITS-1:0] right;
   logic                         is_peak;
   logic                         queue_full;
   peak_type                     push_item;
   peak_type                     rsp_item;
   logic [31:0]                  row_wide;
   logic [31:0]                  col_wide;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[2]);

   always_comb begin
      unique case (cfg_index)
         REG_ROW_COUNT:    prdata = 32'(row_count_ff);
         REG_COLUMN_COUNT: prdata = 32'(column_count_ff);
      endcase
   end

   assign accept = req_valid && !req_stall;

   // the border row reads as zero whatever arrives
   assign bottom   = (row_pos_ff >= row_count_ff);
   assign down     = (req_kind || bottom) ? '0 : req_cell_value;
   assign col_next = (ConfigBits + 1)'(col_pos_ff) + 1'b1;
   assign last_col = (col_next >= {1'b0, column_count_ff});

   // neighbourhood from the chain head
   assign centre = chain_one[0];
   assign up     = chain_two[0];
   assign right  = last_col ? '0 : chain_one[1];

   assign is_peak = (row_pos_ff != '0) && (centre >= up) && (centre >= down)
                    && (centre >= prev_ff) && (centre >= right);

   // a grid ends after the last word of the border row, or on a config write
   assign restart = cfg_write || (accept && last_col && bottom);

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      row_pos_in      = row_pos_ff;
      col_pos_in      = col_pos_ff;
      prev_in         = prev_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_ROW_COUNT:    row_count_in    = clamp_count(pwdata[ConfigBits-1:0], RowLimit);
            REG_COLUMN_COUNT: column_count_in = clamp_count(pwdata[ConfigBits-1:0],
                                                            MAX_COLUMNS);
            default:          row_count_in    = row_count_ff;
         endcase
         row_pos_in = '0;
         col_pos_in = '0;
         prev_in    = '0;
      end else if (accept) begin
         if (last_col) begin
            col_pos_in = '0;
            prev_in    = '0;
            row_pos_in = bottom ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
            prev_in    = centre;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ConfigBits'(1);
         column_count_ff <= ConfigBits'(1);
         row_pos_ff      <= '0;
         col_pos_ff      <= '0;
         prev_ff         <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         row_pos_ff      <= row_pos_in;
         col_pos_ff      <= col_pos_in;
         prev_ff         <= prev_in;
      end
   end

   // row delay chain: the arriving word and the old centre enter at the end of
   // the active length and reach the head one row later
   for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
      logic                         nb_valid;
      logic signed [VALUE_BITS-1:0] nb_one;
      logic signed [VALUE_BITS-1:0] nb_two;

      if (k == MAX_COLUMNS - 1) begin : g_tail
         assign nb_valid = 1'b0;
         assign nb_one   = '0;
         assign nb_two   = '0;
      end else begin : g_link
         assign nb_valid = chain_valid[k+1];
         assign nb_one   = chain_one[k+1];
         assign nb_two   = chain_two[k+1];
      end

      glpf_cell #(
         .VALUE_BITS(VALUE_BITS),
         .INDEX     (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .clear       (restart),
         .shift       (accept),
         .column_count(column_count_ff),
         .entry_one   (down),
         .entry_two   (centre),
         .nb_valid    (nb_valid),
         .nb_one      (nb_one),
         .nb_two      (nb_two),
         .cell_valid  (chain_valid[k]),
         .cell_one    (chain_one[k]),
         .cell_two    (chain_two[k])
      );
   end

   // peak coordinates, low bits of row above and column
   assign row_wide         = 32'(row_pos_ff - 1'b1);
   assign col_wide         = 32'(col_pos_ff);
   assign push_item.row    = row_wide[CoordBits-1:0];
   assign push_item.column = col_wide[CoordBits-1:0];

   glpf_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && is_peak),
      .push_item(push_item),
      .full     (queue_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   assign req_stall       = queue_full;
   assign rsp_peak_row    = rsp_item.row;
   assign rsp_peak_column = rsp_item.column;
   assign rsp_last_of_run = 1'b1;

endmodule

`default_nettype wire

// File: design/glpf_checker.sv
// port-level checks for the grid local peak finder, bound to the top level
// depends on grid_local_peak_finder_macros.svh and glpf_pkg
`default_nettype none
`include "grid_local_peak_finder_macros.svh"

module glpf_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [glpf_pkg::CoordBits-1:0] rsp_peak_row,
   input wire logic [glpf_pkg::CoordBits-1:0] rsp_peak_column,
   input wire logic                         rsp_last_of_run,
   input wire logic                         pready
);

   // a stalled result word holds
   `GLPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_peak_row) && $stable(rsp_peak_column),
      "result word changed while stalled")

   // a fresh result word follows an accepted input word
   `GLPF_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall), "result word without an accepted input word")

   // input is held back only while results are waiting
   `GLPF_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid,
      "input stalled with no result pending")

   // every word closes its own run
   `GLPF_ASSERT_IMP(a_last_set, clock, reset, rsp_valid, rsp_last_of_run && pready,
      "last_of_run low or pready low")

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_peak_row   (rsp_peak_row),
   .rsp_peak_column(rsp_peak_column),
   .rsp_last_of_run(rsp_last_of_run),
   .pready         (pready)
);

`default_nettype wire

// File: test/testbench.sv
// testbench for grid_local_peak_finder: streams grids through the block and checks every peak word
// depends on glpf_pkg and the grid_local_peak_finder rtl
`default_nettype none

module testbench;
   import glpf_pkg::*;

   localparam int MaxColumns  = 256;
   localparam int WatchLimit  = 3000;   // cycles with no handshake anywhere
   localparam int HoldCycles  = 300;    // long receiver hold-off
   localparam int ItemTarget  = 1800;
   localparam int ScriptLines = 23;

   typedef enum logic [1:0] {
      STEP_CELL,
      STEP_ROWS,
      STEP_COLUMNS
   } step_kind;

   // one line of the directed script; arg is the cell value or the raw register data
   typedef struct {
      step_kind what;
      logic     kind;
      int       arg;
      bit       typed;
      bit       hit;
      int       prow;
      int       pcol;
   } script_line;

   typedef struct packed {
      peak_type spot;
      logic     last;
   } peak_word;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // block inputs, known from time zero
   logic                 req_valid      = 1'b0;
   logic                 req_kind       = 1'b0;
   logic signed [15:0]   req_cell_value = '0;
   logic                 rsp_stall      = 1'b0;
   logic                 psel           = 1'b0;
   logic                 penable        = 1'b0;
   logic                 pwrite         = 1'b0;
   logic [2:0]           paddr          = '0;
   logic [31:0]          pwdata         = '0;

   // block outputs
   logic                 req_stall;
   logic                 rsp_valid;
   logic [CoordBits-1:0] rsp_peak_row;
   logic [CoordBits-1:0] rsp_peak_column;
   logic                 rsp_last_of_run;
   logic [31:0]          prdata;
   logic                 pready;

   grid_local_peak_finder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_peak_row    (rsp_peak_row),
      .rsp_peak_column (rsp_peak_column),
      .rsp_last_of_run (rsp_last_of_run),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // ---------------------------------------------------------------------------------------------
   // own model of the grid scan: two line buffers, the centre to the left, and the scan position
   // ---------------------------------------------------------------------------------------------
   logic signed [15:0] line_upper [MaxColumns];   // row above the centre row
   logic signed [15:0] line_centre [MaxColumns];  // centre row, newer row to the left of scan
   logic signed [15:0] left_centre;
   int unsigned        scan_row;
   int unsigned        scan_col;
   int unsigned        rows_in_use;
   int unsigned        cols_in_use;

   peak_word           pending_peaks [$];         // peak words still owed by the block
   int                 mismatches   = 0;
   int                 items_sent   = 0;
   bit                 hold_pending = 1'b0;

   // back to an empty grid with a zero top border
   task automatic wipe_lines();
      foreach (line_upper[i]) begin
         line_upper[i]  = '0;
         line_centre[i] = '0;
      end
      left_centre = '0;
      scan_row    = 0;
      scan_col    = 0;
   endtask

   // zero counts as one, anything above the ceiling counts as the ceiling
   function automatic int unsigned settle_count(input logic [31:0] data,
                                                input int unsigned ceiling);
      int unsigned v;
      v = data[8:0];
      if (v == 0) begin
         return 1;
      end
      if (v > ceiling) begin
         return ceiling;
      end
      return v;
   endfunction

   // one accepted word: decide the centre above it, then move the scan on
   task automatic judge_cell(input logic kind, input logic signed [15:0] raw,
                             output bit hit, output peak_word found);
      logic signed [15:0] below;
      logic signed [15:0] centre;
      logic signed [15:0] up;
      logic signed [15:0] left;
      logic signed [15:0] right;
      int unsigned        c;
      bit                 border;
      c      = scan_col;
      border = scan_row >= rows_in_use;
      below  = (kind || border) ? 16'sd0 : raw;
      centre = line_centre[c];
      hit    = 1'b0;
      found  = '0;
      if (scan_row >= 1) begin
         up   = line_upper[c];
         left = (c == 0) ? 16'sd0 : left_centre;
         if (c + 1 < cols_in_use) begin
            right = line_centre[c + 1];
         end else begin
            right = 16'sd0;
         end
         if (centre >= up && centre >= below && centre >= left && centre >= right) begin
            hit              = 1'b1;
            found.spot.row    = CoordBits'(scan_row - 1);
            found.spot.column = CoordBits'(c);
            found.last        = 1'b1;
         end
      end
      left_centre    = centre;
      line_upper[c]  = centre;
      line_centre[c] = below;
      c++;
      if (c >= cols_in_use) begin
         c           = 0;
         left_centre = '0;
         if (border) begin
            wipe_lines();
            return;
         end
         scan_row++;
      end
      scan_col = c;
   endtask

   // ---------------------------------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------------------------------

   // mostly back to back, sometimes a short pause, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // offer one word and hold it until accepted; typed rows carry their own expectation
   task automatic send_cell(input logic kind, input logic signed [15:0] value, input bit smooth,
                            input bit typed, input bit want_hit, input int prow, input int pcol);
      int       gap;
      bit       hit;
      peak_word found;
      gap = smooth ? 0 : idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_cell_value <= value;
      do @(posedge clock); while (req_stall);
      judge_cell(kind, value, hit, found);
      if (typed) begin
         hit               = want_hit;
         found.spot.row    = CoordBits'(prow);
         found.spot.column = CoordBits'(pcol);
         found.last        = 1'b1;
      end
      if (hit) begin
         pending_peaks.push_back(found);
      end
      items_sent++;
   endtask

   // drop valid and let every owed peak word arrive, then a few spare cycles
   task automatic settle_down(input int spare);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_peaks.size() != 0) @(posedge clock);
      repeat (spare) @(posedge clock);
   endtask

   // apb write followed by a read back of the clamped value; either write restarts the grid
   task automatic write_register(input reg_index_type which, input logic [31:0] data);
      int unsigned kept;
      kept = settle_count(data, (which == REG_ROW_COUNT) ? RowLimit : MaxColumns);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (which == REG_ROW_COUNT) begin
         rows_in_use = kept;
      end else begin
         cols_in_use = kept;
      end
      wipe_lines();
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(kept)) begin
         $display("%0t: register %s read back: expected %0d, actual %0d",
                  $time, which.name(), kept, prdata);
         mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // value spread per grid: narrow ranges give plenty of ties and peaks
   function automatic logic signed [15:0] pick_value(input int mode);
      int t;
      case (mode)
         0: begin
            t = int'($urandom_range(0, 4)) - 2;
            return 16'(t);
         end
         1: return 16'($urandom_range(0, 3));
         2: return 16'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sd0;
               3: return 16'sd1;
               default: return -16'sd1;
            endcase
         end
      endcase
   endfunction

   // real rows then the flush border row; noise flips the kind, prefix cuts the grid short
   task automatic run_grid(input int prefix, input int mode, input int noise, input bit smooth);
      int   total;
      logic kind;
      total = (rows_in_use + 1) * cols_in_use;
      if (prefix > 0 && prefix < total) begin
         total = prefix;
      end
      for (int i = 0; i < total; i++) begin
         kind = (i >= rows_in_use * cols_in_use);
         if ($urandom_range(0, 99) < noise) begin
            kind = ~kind;
         end
         send_cell(kind, pick_value(mode), smooth, 1'b0, 1'b0, 0, 0);
      end
   endtask

   // directed script, run straight after reset with both counts at one
   script_line plan [ScriptLines];

   initial begin
      script_line line;
      int         mode;
      int         noise;
      int         prefix;
      bit         smooth;
      bit         need_restart;
      bit         hold_done;
      int         r;
      logic [31:0] upper;

      rows_in_use = 1;
      cols_in_use = 1;
      wipe_lines();

      plan = '{
         // one by one grid: the centre is decided by the flush word below it
         '{STEP_CELL,    1'b0,  32767, 1'b1, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,      0, 1'b1, 1'b1, 0, 0},
         '{STEP_CELL,    1'b0, -32768, 1'b1, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,     -1, 1'b1, 1'b0, 0, 0},
         // all zero grid ties with the border, and a real word in the border row reads as zero
         '{STEP_CELL,    1'b0,      0, 1'b1, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,     -5, 1'b1, 1'b1, 0, 0},
         '{STEP_CELL,    1'b0,     -1, 1'b1, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,    100, 1'b1, 1'b0, 0, 0},
         // two by three grid with a flush word inside the real rows
         '{STEP_ROWS,    1'b0,      2, 1'b0, 1'b0, 0, 0},
         '{STEP_COLUMNS, 1'b0,      3, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,      7, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,  32767, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0, -32768, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,    999, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,      3, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,  32767, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,      0, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,      5, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,     -7, 1'b0, 1'b0, 0, 0},
         // zero counts clamp back to one
         '{STEP_ROWS,    1'b0,      0, 1'b0, 1'b0, 0, 0},
         '{STEP_COLUMNS, 1'b0,      0, 1'b0, 1'b0, 0, 0},
         '{STEP_CELL,    1'b0,      1, 1'b1, 1'b0, 0, 0},
         '{STEP_CELL,    1'b1,      0, 1'b1, 1'b1, 0, 0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         line = plan[i];
         case (line.what)
            STEP_CELL: begin
               send_cell(line.kind, 16'(line.arg), 1'b0, line.typed, line.hit,
                         line.prow, line.pcol);
            end
            STEP_ROWS: begin
               settle_down(8);
               write_register(REG_ROW_COUNT, 32'(line.arg));
            end
            default: begin
               settle_down(8);
               write_register(REG_COLUMN_COUNT, 32'(line.arg));
            end
         endcase
      end

      // largest sizes, each once: tallest grid, widest grid, and an oversize pair cut short
      settle_down(8);
      write_register(REG_ROW_COUNT, 32'd511);
      write_register(REG_COLUMN_COUNT, 32'd1);
      run_grid(0, 0, 0, 1'b0);
      settle_down(8);
      write_register(REG_ROW_COUNT, 32'd1);
      write_register(REG_COLUMN_COUNT, 32'hA5A5_A100);
      run_grid(0, 1, 0, 1'b0);
      settle_down(8);
      write_register(REG_ROW_COUNT, 32'd300);
      write_register(REG_COLUMN_COUNT, 32'd256);
      run_grid(120, 2, 5, 1'b0);
      need_restart = 1'b1;
      hold_done    = 1'b0;

      // small grids with random content, some noisy, some cut short
      while (items_sent < ItemTarget) begin
         r      = $urandom_range(0, 99);
         mode   = (r < 35) ? 0 : (r < 60) ? 1 : (r < 85) ? 2 : 3;
         noise  = ($urandom_range(0, 99) < 70) ? 0 : 10;
         smooth = ($urandom_range(0, 99) < 25);
         prefix = 0;
         if (!hold_done && items_sent > 900) begin
            // long receiver hold-off while a dense grid streams in
            settle_down(8);
            write_register(REG_ROW_COUNT, 32'd6);
            write_register(REG_COLUMN_COUNT, 32'd40);
            hold_pending = 1'b1;
            hold_done    = 1'b1;
            run_grid(0, 1, 0, 1'b1);
            need_restart = 1'b0;
            continue;
         end
         if (need_restart || $urandom_range(0, 2) != 0) begin
            settle_down(8);
            upper = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
            r     = $urandom_range(0, 99);
            if (r < 80 || need_restart) begin
               if ($urandom_range(0, 3) == 0) begin
                  write_register(REG_ROW_COUNT, {upper[22:0], 9'($urandom_range(0, 3))});
                  write_register(REG_COLUMN_COUNT, {upper[22:0], 9'($urandom_range(9, 40))});
               end else begin
                  write_register(REG_ROW_COUNT, {upper[22:0], 9'($urandom_range(0, 6))});
                  write_register(REG_COLUMN_COUNT, {upper[22:0], 9'($urandom_range(1, 8))});
               end
            end else if (r < 90) begin
               write_register(REG_ROW_COUNT, {upper[22:0], 9'($urandom_range(1, 6))});
            end else begin
               write_register(REG_COLUMN_COUNT, {upper[22:0], 9'($urandom_range(1, 8))});
            end
         end
         need_restart = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            prefix       = $urandom_range(1, (rows_in_use + 1) * cols_in_use);
            need_restart = 1'b1;
         end
         run_grid(prefix, mode, noise, smooth);
      end

      // drain and verdict
      settle_down(16);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------------------------

   // receiver stall pattern: free runs, short stalls, rare long ones, and the one long hold-off
   initial begin
      bit stall_now;
      int span;
      int r;
      forever begin
         if (hold_pending) begin
            stall_now    = 1'b1;
            span         = HoldCycles;
            hold_pending = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               stall_now = 1'b0;
               span      = $urandom_range(20, 80);
            end else if (r < 75) begin
               stall_now = 1'b0;
               span      = $urandom_range(1, 3);
            end else if (r < 93) begin
               stall_now = 1'b1;
               span      = $urandom_range(1, 4);
            end else if (r < 99) begin
               stall_now = 1'b1;
               span      = $urandom_range(5, 15);
            end else begin
               stall_now = 1'b1;
               span      = $urandom_range(30, 60);
            end
         end
         @(negedge clock);
         rsp_stall <= stall_now;
         repeat (span - 1) @(negedge clock);
      end
   end

   // every accepted peak word against the oldest one owed
   always @(posedge clock) begin
      peak_word owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_peaks.size() == 0) begin
            $display("%0t: unexpected peak word: expected none, actual row %0d column %0d",
                     $time, rsp_peak_row, rsp_peak_column);
            mismatches++;
         end else begin
            owed = pending_peaks.pop_front();
            if (rsp_peak_row !== owed.spot.row) begin
               $display("%0t: peak_row: expected %0d, actual %0d",
                        $time, owed.spot.row, rsp_peak_row);
               mismatches++;
            end
            if (rsp_peak_column !== owed.spot.column) begin
               $display("%0t: peak_column: expected %0d, actual %0d",
                        $time, owed.spot.column, rsp_peak_column);
               mismatches++;
            end
            if (rsp_last_of_run !== owed.last) begin
               $display("%0t: last_of_run: expected %0d, actual %0d",
                        $time, owed.last, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long with no handshake on any port ends the run
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WatchLimit) begin
         $display("%0t: watchdog expired with %0d peak words outstanding",
                  $time, pending_peaks.size());
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/glpf_pkg.sv
design/glpf_cell.sv
design/glpf_out_queue.sv
design/grid_local_peak_finder.sv
design/glpf_checker.sv
test/testbench.sv
